// ----- rtl/epd_lut_pkg.sv -----
// Shared types, register offsets and codes for the e-paper update register block.
// Used by epd_update_lut_status_registers and the testbench; depends on nothing.
`default_nettype none

package epd_lut_pkg;

    // Word index of a 32-bit register (byte address bits 10..2).
    localparam int IDX_W = 9;
    typedef logic [IDX_W-1:0] widx_t;

    // Item command codes.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_BUF_DELAY = 1'b0;
    localparam logic CFG_LUT_DELAY = 1'b1;

    // Alias codes taken from byte address bits 3..2.
    localparam logic [1:0] ALIAS_NONE = 2'd0;
    localparam logic [1:0] ALIAS_SET  = 2'd1;
    localparam logic [1:0] ALIAS_CLR  = 2'd2;
    localparam logic [1:0] ALIAS_TOG  = 2'd3;

    // Register word indexes (byte offset divided by four).
    localparam widx_t WI_CTRL     = 9'h000;
    localparam widx_t WI_FORMAT   = 9'h014;
    localparam widx_t WI_FIFOCTRL = 9'h028;
    localparam widx_t WI_UPD_CTRL = 9'h058;
    localparam widx_t WI_IRQ_MASK = 9'h100;
    localparam widx_t WI_IRQ      = 9'h108;
    localparam widx_t WI_LUTS     = 9'h110;
    localparam widx_t WI_NEXTLUT  = 9'h118;
    localparam widx_t WI_STATUS   = 9'h128;

    // Bit positions and reset values.
    localparam int CTRL_SFTRST_BIT  = 31;
    localparam int CTRL_CLKGATE_BIT = 30;
    localparam int UPD_PAUSE_BIT    = 3;
    localparam int IRQ_WB_BIT       = 16;
    localparam int IRQ_UPD_BIT      = 22;
    localparam int STATUS_BUSY_BIT  = 0;
    localparam logic [31:0] NEXTLUT_FLAG    = 32'h0000_0100;
    localparam logic [31:0] CTRL_RESET      = 32'h4000_0000;
    localparam logic [23:0] BUF_DELAY_RESET = 24'd1000;
    localparam logic [23:0] LUT_DELAY_RESET = 24'd10000;

    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] address;
        logic [31:0] write_data;
    } epd_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
    } epd_out_t;

    // True for a base register that also answers at its set, clear and toggle aliases.
    function automatic logic has_alias(input widx_t base);
        return (base == WI_CTRL) || (base == WI_FORMAT) || (base == WI_FIFOCTRL) ||
               (base == WI_IRQ_MASK) || (base == WI_IRQ) || (base == WI_LUTS) ||
               (base == WI_STATUS);
    endfunction

    // True for a register held in flip-flops rather than in the word memory.
    function automatic logic in_flops(input widx_t idx);
        return (idx == WI_CTRL) || (idx == WI_IRQ_MASK) || (idx == WI_IRQ) ||
               (idx == WI_LUTS) || (idx == WI_STATUS);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/epd_lut_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module epd_lut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the contents from before a write in the same cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/epd_update_lut_status_registers.sv -----
// Top level of the e-paper update register block: word memory, status registers, countdowns.
// Depends on epd_lut_pkg and epd_lut_ram.
`default_nettype none

// Each item (read, write or tick) passes the second-stage register and the output register
// to give one result item, and a new item can be accepted every cycle, so the sustained rate
// is one item per cycle while m_ready stays high. The general register words sit in one RAM
// whose read is issued in the accept cycle and whose write-back happens when the item leaves
// the second stage; a read of the word being written back in that same cycle is forwarded.
// CTRL, IRQ_MASK, IRQ, STATUS_LUTS and STATUS live in flip-flops. After reset the RAM is
// cleared one word per cycle over all REG_WORDS words (512 by default), during which s_ready
// stays low; configuration writes are taken at all times.
module epd_update_lut_status_registers #(
    parameter int REG_WORDS = 512
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire epd_lut_pkg::epd_in_t s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output epd_lut_pkg::epd_out_t     m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_index,
    input  wire logic [23:0]          cfg_wdata
);

    import epd_lut_pkg::*;

    localparam int AW = $clog2(REG_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(REG_WORDS - 1);
    localparam logic [IDX_W+1:0] WORDS_LIM = (IDX_W + 2)'(REG_WORDS);

    // Configuration and state registers.
    logic [23:0] buf_delay_reg, lut_delay_reg;
    logic [31:0] ctrl_reg, irq_mask_reg, irq_reg, luts_reg, status_reg;
    logic [31:0] ctrl_next, irq_mask_next, irq_next, luts_next, status_next;
    logic [15:0] pend_reg, pend_next;
    logic [23:0] bcnt_reg, bcnt_next, lcnt_reg, lcnt_next;

    // Clearing pass.
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Second stage of an item.
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_cmd_reg;
    widx_t       s1_idx_reg;
    logic [31:0] s1_wdata_reg;
    logic        s1_byp_reg;
    logic [31:0] s1_byp_data_reg;
    logic        s1_go;

    // Output register.
    logic     m_valid_reg, m_valid_next;
    epd_out_t m_data_reg;

    // RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          accept;

    // First stage: decode the incoming item enough to pick the word to read.
    widx_t      in_idx, in_base, in_rd_idx;
    logic [1:0] in_alias;

    assign in_idx    = s_data.address[10:2];
    assign in_alias  = in_idx[1:0];
    assign in_base   = {in_idx[IDX_W-1:2], 2'b00};
    assign in_rd_idx = (s_data.command == CMD_WRITE && in_alias != ALIAS_NONE &&
                        has_alias(in_base)) ? in_base : in_idx;
    assign ram_raddr = AW'(in_rd_idx);

    assign s1_go   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_busy_reg && (!s1_valid_reg || s1_go);
    assign accept  = s_valid && s_ready;

    epd_lut_ram #(
        .WIDTH (32),
        .DEPTH (REG_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Second stage: read, modify and write back, then apply submit and tick events.
    widx_t       s1_base, s1_tgt;
    logic [1:0]  s1_alias;
    logic        s1_alias_w;
    logic [31:0] mem_q, old_val, new_val, rd_val;
    logic [15:0] lut_bit;
    logic [3:0]  free_lut;
    logic        free_found;

    assign s1_alias   = s1_idx_reg[1:0];
    assign s1_base    = {s1_idx_reg[IDX_W-1:2], 2'b00};
    assign s1_alias_w = (s1_alias != ALIAS_NONE) && has_alias(s1_base);
    assign s1_tgt     = s1_alias_w ? s1_base : s1_idx_reg;
    assign mem_q      = s1_byp_reg ? s1_byp_data_reg : ram_rdata;
    assign lut_bit    = 16'd1 << s1_wdata_reg[19:16];

    // Lowest LUT whose active bit is clear.
    always_comb begin
        free_lut   = '0;
        free_found = 1'b0;
        for (int n = 15; n >= 0; n--) begin
            if (!luts_reg[n]) begin
                free_lut   = 4'(n);
                free_found = 1'b1;
            end
        end
    end

    always_comb begin
        ctrl_next     = ctrl_reg;
        irq_mask_next = irq_mask_reg;
        irq_next      = irq_reg;
        luts_next     = luts_reg;
        status_next   = status_reg;
        pend_next     = pend_reg;
        bcnt_next     = bcnt_reg;
        lcnt_next     = lcnt_reg;
        rd_val        = '0;
        old_val       = '0;
        new_val       = '0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(s1_tgt);
        ram_wdata     = '0;

        case (s1_cmd_reg)
            CMD_READ: begin
                if (s1_idx_reg == WI_NEXTLUT) begin
                    rd_val = free_found ? (NEXTLUT_FLAG | {28'd0, free_lut}) : '0;
                end else if (s1_idx_reg == WI_CTRL) begin
                    rd_val = ctrl_reg;
                end else if (s1_idx_reg == WI_IRQ_MASK) begin
                    rd_val = irq_mask_reg;
                end else if (s1_idx_reg == WI_IRQ) begin
                    rd_val = irq_reg;
                end else if (s1_idx_reg == WI_LUTS) begin
                    rd_val = luts_reg;
                end else if (s1_idx_reg == WI_STATUS) begin
                    rd_val = status_reg;
                end else if ({2'b00, s1_idx_reg} < WORDS_LIM) begin
                    rd_val = mem_q;
                end
            end
            CMD_WRITE: begin
                // Current value of the word that an alias access modifies.
                if (s1_tgt == WI_CTRL) begin
                    old_val = ctrl_reg;
                end else if (s1_tgt == WI_IRQ_MASK) begin
                    old_val = irq_mask_reg;
                end else if (s1_tgt == WI_IRQ) begin
                    old_val = irq_reg;
                end else if (s1_tgt == WI_LUTS) begin
                    old_val = luts_reg;
                end else if (s1_tgt == WI_STATUS) begin
                    old_val = status_reg;
                end else begin
                    old_val = mem_q;
                end

                if (s1_alias_w) begin
                    case (s1_alias)
                        ALIAS_SET: new_val = old_val | s1_wdata_reg;
                        ALIAS_CLR: new_val = old_val & ~s1_wdata_reg;
                        default:   new_val = old_val ^ s1_wdata_reg;
                    endcase
                end else begin
                    new_val = s1_wdata_reg;
                end

                // Store the word; soft reset forces the clock gate on.
                if (s1_tgt == WI_CTRL) begin
                    ctrl_next = new_val;
                    ctrl_next[CTRL_CLKGATE_BIT] = new_val[CTRL_CLKGATE_BIT] |
                                                  new_val[CTRL_SFTRST_BIT];
                end else if (s1_tgt == WI_IRQ_MASK) begin
                    irq_mask_next = new_val;
                end else if (s1_tgt == WI_IRQ) begin
                    irq_next = new_val;
                end else if (s1_tgt == WI_LUTS) begin
                    luts_next = new_val;
                end else if (s1_tgt == WI_STATUS) begin
                    status_next = new_val;
                end else if ({2'b00, s1_tgt} < WORDS_LIM) begin
                    ram_we    = s1_go;
                    ram_wdata = new_val;
                end

                // Update submit.
                if (s1_idx_reg == WI_UPD_CTRL) begin
                    status_next[STATUS_BUSY_BIT] = 1'b1;
                    luts_next = luts_next | {16'd0, lut_bit};
                    pend_next = pend_reg | lut_bit;
                    if (s1_wdata_reg[UPD_PAUSE_BIT]) begin
                        irq_next[IRQ_UPD_BIT] = 1'b1;
                    end else begin
                        bcnt_next = (buf_delay_reg == '0) ? 24'd1 : buf_delay_reg;
                        lcnt_next = (lut_delay_reg == '0) ? 24'd1 : lut_delay_reg;
                    end
                end
            end
            CMD_TICK: begin
                // Working-buffer completion comes before LUT completion.
                if (bcnt_reg != '0) begin
                    bcnt_next = bcnt_reg - 24'd1;
                    if (bcnt_reg == 24'd1) begin
                        status_next[STATUS_BUSY_BIT] = 1'b0;
                        irq_next[IRQ_WB_BIT] = 1'b1;
                    end
                end
                if (lcnt_reg != '0) begin
                    lcnt_next = lcnt_reg - 24'd1;
                    if (lcnt_reg == 24'd1) begin
                        pend_next = '0;
                        luts_next = luts_next & ~{16'd0, pend_reg};
                        irq_next  = irq_next | {16'd0, pend_reg};
                    end
                end
            end
            default: begin
            end
        endcase

        // The clearing pass owns the write port until it ends.
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = s1_go ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            buf_delay_reg <= BUF_DELAY_RESET;
            lut_delay_reg <= LUT_DELAY_RESET;
            ctrl_reg      <= CTRL_RESET;
            irq_mask_reg  <= '0;
            irq_reg       <= '0;
            luts_reg      <= '0;
            status_reg    <= '0;
            pend_reg      <= '0;
            bcnt_reg      <= '0;
            lcnt_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_WORD) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BUF_DELAY: buf_delay_reg <= cfg_wdata;
                    CFG_LUT_DELAY: lut_delay_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s1_go) begin
                ctrl_reg     <= ctrl_next;
                irq_mask_reg <= irq_mask_next;
                irq_reg      <= irq_next;
                luts_reg     <= luts_next;
                status_reg   <= status_next;
                pend_reg     <= pend_next;
                bcnt_reg     <= bcnt_next;
                lcnt_reg     <= lcnt_next;
            end
        end
    end

    // Item payload, forwarding capture and result register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg      <= s_data.command;
            s1_idx_reg      <= in_idx;
            s1_wdata_reg    <= s_data.write_data;
            s1_byp_reg      <= ram_we && (ram_waddr == ram_raddr);
            s1_byp_data_reg <= ram_wdata;
        end
        if (s1_go) begin
            m_data_reg.read_data <= rd_val;
            m_data_reg.irq_line  <= |(irq_mask_next & irq_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // No item enters while the memory is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready)
        else $error("item accepted during memory clearing");

    // Soft reset always leaves the clock gate set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg[CTRL_SFTRST_BIT] |-> ctrl_reg[CTRL_CLKGATE_BIT])
        else $error("soft reset without clock gate");

    // A submit marks the working buffer busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && s1_cmd_reg == CMD_WRITE && s1_idx_reg == WI_UPD_CTRL)
        |=> status_reg[STATUS_BUSY_BIT])
        else $error("submit did not set working buffer busy");

    // The last buffer tick completes the working buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && s1_cmd_reg == CMD_TICK && bcnt_reg == 24'd1)
        |=> (bcnt_reg == '0) && !status_reg[STATUS_BUSY_BIT] && irq_reg[IRQ_WB_BIT])
        else $error("buffer countdown expiry not applied");

    // Every finished second stage yields a result item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_go |=> m_valid_reg)
        else $error("result item lost");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the e-paper update register block: directed rows, then random
// register traffic over several completion-delay settings, checked against a local model.
// Depends on epd_lut_pkg and the epd_update_lut_status_registers RTL only.
`default_nettype none

module testbench;
    import epd_lut_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MIRROR_WORDS = 512;
    localparam int          PHASES       = 7;
    localparam int          PHASE_ITEMS  = 215;
    localparam int          HOLD_PHASE   = 1;
    localparam int          STEADY_PHASE = 4;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    // One row of the directed part; want is only used where fixed is set.
    typedef struct packed {
        epd_in_t  stim;
        logic     fixed;
        epd_out_t want;
    } row_t;

    localparam row_t DIRECTED [25] = '{
        '{'{CMD_READ,   11'h000, 32'h0000_0000}, 1'b1, '{CTRL_RESET,   1'b0}},
        '{'{CMD_READ,   11'h460, 32'h0000_0000}, 1'b1, '{NEXTLUT_FLAG, 1'b0}},
        '{'{CMD_READ,   11'h7ff, 32'h0000_0000}, 1'b1, '{32'h0,        1'b0}},
        '{'{CMD_UNUSED, 11'h000, 32'hffff_ffff}, 1'b1, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h400, 32'hffff_ffff}, 1'b1, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h000, 32'h8000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h000, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h008, 32'hffff_ffff}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h0ac, 32'ha5a5_a5a5}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h0a0, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h054, 32'h0000_ffff}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h058, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h160, 32'h000f_0008}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h440, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h4a0, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h444, 32'h0000_ffff}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h460, 32'h0000_0000}, 1'b1, '{32'h0,        1'b1}},
        '{'{CMD_WRITE,  11'h448, 32'hffff_ffff}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h160, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_TICK,   11'h000, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h42c, 32'h0040_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h7fc, 32'hffff_ffff}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h7fe, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_WRITE,  11'h164, 32'h1234_5678}, 1'b0, '{32'h0,        1'b0}},
        '{'{CMD_READ,   11'h167, 32'h0000_0000}, 1'b0, '{32'h0,        1'b0}}
    };

    // Completion delays per phase: zero, shortest, short, longest, mixed.
    localparam logic [23:0] PHASE_WB_DELAY  [PHASES] =
        '{24'd0, 24'd1, 24'd3, 24'hffffff, 24'd12, 24'd7,  24'hffffff};
    localparam logic [23:0] PHASE_LUT_DELAY [PHASES] =
        '{24'd0, 24'd1, 24'd17, 24'hffffff, 24'd5, 24'd40, 24'd2};

    // Registers that the random traffic concentrates on.
    localparam widx_t BUSY_REGS [9] = '{WI_CTRL, WI_FORMAT, WI_FIFOCTRL, WI_UPD_CTRL,
                                        WI_IRQ_MASK, WI_IRQ, WI_LUTS, WI_NEXTLUT, WI_STATUS};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    epd_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    epd_out_t    m_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_BUF_DELAY;
    logic [23:0] cfg_wdata = '0;

    // Local copy of the register block state.
    logic [31:0] reg_mirror [MIRROR_WORDS];
    logic [15:0] lut_pend_mask;
    logic [23:0] wb_left, lut_left;
    logic [23:0] wb_delay, lut_delay;

    epd_out_t    expected_results [$];
    epd_out_t    due;
    int          errors, items_sent, results_seen, wb_finishes, lut_finishes;
    int          cycle_count, hold_left;
    bit          steady, hold_req, hold_done;

    epd_update_lut_status_registers u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Applies one item to the local state and returns the result it should give.
    function automatic epd_out_t register_access(input epd_in_t stim);
        widx_t       idx, base;
        logic [1:0]  sel;
        logic        aliased;
        logic [3:0]  lut;
        logic [31:0] word;
        epd_out_t    res;
        idx     = stim.address[10:2];
        base    = {idx[8:2], 2'b00};
        sel     = idx[1:0];
        aliased = (base == WI_CTRL) || (base == WI_FORMAT) || (base == WI_FIFOCTRL) ||
                  (base == WI_IRQ_MASK) || (base == WI_IRQ) || (base == WI_LUTS) ||
                  (base == WI_STATUS);
        res.read_data = '0;
        case (stim.command)
            CMD_READ: begin
                if (idx == WI_NEXTLUT) begin
                    // Lowest free LUT wins, so scan downwards and keep the last hit.
                    for (int n = 15; n >= 0; n--) begin
                        if (!reg_mirror[WI_LUTS][n]) res.read_data = NEXTLUT_FLAG | 32'(n);
                    end
                end else begin
                    res.read_data = reg_mirror[idx];
                end
            end
            CMD_WRITE: begin
                if (sel != ALIAS_NONE && aliased) begin
                    word = reg_mirror[base];
                    case (sel)
                        ALIAS_SET: word = word | stim.write_data;
                        ALIAS_CLR: word = word & ~stim.write_data;
                        default:   word = word ^ stim.write_data;
                    endcase
                    reg_mirror[base] = word;
                end else begin
                    reg_mirror[idx] = stim.write_data;
                end
                // Soft reset always drags the clock gate with it.
                if (base == WI_CTRL && reg_mirror[WI_CTRL][CTRL_SFTRST_BIT])
                    reg_mirror[WI_CTRL][CTRL_CLKGATE_BIT] = 1'b1;
                // Update submit marks buffer busy and the LUT active and pending.
                if (idx == WI_UPD_CTRL) begin
                    lut = stim.write_data[19:16];
                    reg_mirror[WI_STATUS][STATUS_BUSY_BIT] = 1'b1;
                    reg_mirror[WI_LUTS][lut] = 1'b1;
                    lut_pend_mask[lut] = 1'b1;
                    if (stim.write_data[UPD_PAUSE_BIT]) begin
                        reg_mirror[WI_IRQ][IRQ_UPD_BIT] = 1'b1;
                    end else begin
                        wb_left  = (wb_delay == '0) ? 24'd1 : wb_delay;
                        lut_left = (lut_delay == '0) ? 24'd1 : lut_delay;
                    end
                end
            end
            CMD_TICK: begin
                // Buffer completion is applied before LUT completion.
                if (wb_left != '0) begin
                    wb_left = wb_left - 24'd1;
                    if (wb_left == '0) begin
                        reg_mirror[WI_STATUS][STATUS_BUSY_BIT] = 1'b0;
                        reg_mirror[WI_IRQ][IRQ_WB_BIT] = 1'b1;
                        wb_finishes++;
                    end
                end
                if (lut_left != '0) begin
                    lut_left = lut_left - 24'd1;
                    if (lut_left == '0) begin
                        reg_mirror[WI_LUTS] = reg_mirror[WI_LUTS] & ~{16'h0, lut_pend_mask};
                        reg_mirror[WI_IRQ]  = reg_mirror[WI_IRQ] | {16'h0, lut_pend_mask};
                        lut_pend_mask = '0;
                        lut_finishes++;
                    end
                end
            end
            default: ;
        endcase
        res.irq_line = |(reg_mirror[WI_IRQ_MASK] & reg_mirror[WI_IRQ]);
        return res;
    endfunction

    // Offers one item, holds it until taken, then records the result it should give.
    task automatic send(input epd_in_t stim, input logic fixed, input epd_out_t want);
        epd_out_t guess;
        s_valid <= 1'b1;
        s_data  <= stim;
        do @(posedge aclk); while (!s_ready);
        guess = register_access(stim);
        expected_results.push_back(fixed ? want : guess);
        items_sent++;
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Waits for every outstanding result and lets the pipeline run empty.
    task automatic drain();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both completion delays while the block is idle.
    task automatic set_delays(input logic [23:0] wb_ticks, input logic [23:0] lut_ticks);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BUF_DELAY;
        cfg_wdata <= wb_ticks;
        @(posedge aclk);
        cfg_index <= CFG_LUT_DELAY;
        cfg_wdata <= lut_ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        wb_delay  = wb_ticks;
        lut_delay = lut_ticks;
    endtask

    // Result side: random back-pressure, plus one long hold-off when asked for.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    // Compare each result item with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result item, read_data %h irq_line %b",
                         $time, m_data.read_data, m_data.irq_line);
                errors++;
            end else begin
                due = expected_results.pop_front();
                if (m_data.read_data !== due.read_data) begin
                    $display("%0t: read_data mismatch, expected %h, got %h",
                             $time, due.read_data, m_data.read_data);
                    errors++;
                end
                if (m_data.irq_line !== due.irq_line) begin
                    $display("%0t: irq_line mismatch, expected %b, got %b",
                             $time, due.irq_line, m_data.irq_line);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("** epd_update_lut_status_registers: FAILED **");
        $finish;
    end

    // Main sequence: reset, directed rows, then random traffic per delay setting.
    initial begin
        epd_in_t stim;
        widx_t   idx;
        int      roll;
        foreach (reg_mirror[i]) reg_mirror[i] = '0;
        reg_mirror[WI_CTRL] = CTRL_RESET;
        lut_pend_mask = '0;
        wb_left       = '0;
        lut_left      = '0;
        wb_delay      = BUF_DELAY_RESET;
        lut_delay     = LUT_DELAY_RESET;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < $size(DIRECTED); k++)
            send(DIRECTED[k].stim, DIRECTED[k].fixed, DIRECTED[k].want);

        for (int p = 0; p < PHASES; p++) begin
            s_valid <= 1'b0;
            drain();
            set_delays(PHASE_WB_DELAY[p], PHASE_LUT_DELAY[p]);
            steady = (p == STEADY_PHASE);
            if (p == HOLD_PHASE) hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                idx  = BUSY_REGS[$urandom_range(0, 8)] | widx_t'($urandom_range(0, 3));
                stim.command    = CMD_READ;
                stim.address    = {idx, 2'($urandom_range(0, 3))};
                stim.write_data = $urandom;
                if (roll < 30) begin
                    stim.command = CMD_TICK;
                end else if (roll < 45) begin
                    // Update submit, paused about one time in four.
                    stim.command = CMD_WRITE;
                    stim.address = {WI_UPD_CTRL, 2'($urandom_range(0, 3))};
                    stim.write_data[UPD_PAUSE_BIT] = ($urandom_range(0, 3) == 0);
                end else if (roll < 88 && roll >= 68) begin
                    stim.command = CMD_WRITE;
                end else if (roll < 95 && roll >= 88) begin
                    stim.command = 2'($urandom_range(0, 3));
                    stim.address = 11'($urandom_range(0, 2047));
                end else if (roll >= 95) begin
                    stim.address = {WI_NEXTLUT, 2'b00};
                end
                send(stim, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        steady = 1'b0;
        drain();
        repeat (4) @(posedge aclk);
        $display("Covered %0d items over %0d delay settings: %0d buffer and %0d LUT completions.",
                 items_sent, PHASES + 1, wb_finishes, lut_finishes);
        $display("Compared %0d result items, %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("** epd_update_lut_status_registers: PASSED **");
        end else begin
            $display("** epd_update_lut_status_registers: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/epd_lut_pkg.sv
rtl/epd_lut_ram.sv
rtl/epd_update_lut_status_registers.sv
tb/sv/testbench.sv
